// File: rtl/qdpf_pkg.sv
// Package for the quadrature decoder with period filter.
// Holds field widths, reset values and filter constants; no dependencies.
package qdpf_pkg;

  localparam int COUNT_WIDTH_DEF  = 32;
  localparam int PERIOD_WIDTH_DEF = 24;

  localparam int POSITION_W   = 32;
  localparam int PERIOD_OUT_W = 24;
  localparam int MIN_PERIOD_W = 16;

  localparam logic [MIN_PERIOD_W-1:0] MIN_PERIOD_RESET = 16'd400;

  // 1/3 approximated as 341/1024
  localparam int AVG_MUL   = 341;
  localparam int AVG_MUL_W = 9;
  localparam int AVG_SHIFT = 10;

endpackage

// File: rtl/qdpf_ifs.sv
// Valid/ready channel interfaces for the quadrature decoder block.
// Depends on qdpf_pkg for field widths.
interface qdpf_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  modport source (output valid, pin_a, pin_b, input ready);
  modport sink   (input valid, pin_a, pin_b, output ready);
endinterface

interface qdpf_out_if import qdpf_pkg::*; ;
  logic                         valid;
  logic                         ready;
  logic signed [POSITION_W-1:0] position;
  logic                         clockwise;
  logic [PERIOD_OUT_W-1:0]      period_filtered;
  logic                         illegal;
  modport source (output valid, position, clockwise, period_filtered, illegal, input ready);
  modport sink   (input valid, position, clockwise, period_filtered, illegal, output ready);
endinterface

interface qdpf_cfg_if import qdpf_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic [MIN_PERIOD_W-1:0] min_period;
  modport source (output valid, min_period, input ready);
  modport sink   (input valid, min_period, output ready);
endinterface

// File: rtl/quadrature_decoder_with_period_filter_unit.sv
// x4 quadrature decoder with a 3-tap averaged A-edge interval.
// Depends on qdpf_pkg and the channel interfaces in qdpf_ifs.sv.
//
// Takes one A/B sample per item and returns one result per item. An item is
// accepted every cycle unless a result is stalled with another item waiting;
// it passes an input register, then the decode, the interval counter and the
// (sum*341)>>10 average update the state while the result register loads.
// The input register lets one item be taken while a result waits.
// The min_period register may be written at any cycle (ready is always high).
module quadrature_decoder_with_period_filter_unit import qdpf_pkg::*; #(
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qdpf_in_if.sink     in_i,
  qdpf_out_if.source  out_o,
  qdpf_cfg_if.sink    cfg_i
);

  localparam int SumW  = PERIOD_WIDTH + 2;
  localparam int ProdW = SumW + AVG_MUL_W;

  logic                    in_v_q;
  logic                    pin_a_q, pin_b_q;
  logic                    out_v_q;
  logic                    advance;

  logic [MIN_PERIOD_W-1:0] min_period_q;
  logic                    last_a_q, last_b_q;
  logic [COUNT_WIDTH-1:0]  count_q, count_d;
  logic                    dir_q, dir_d;
  logic [PERIOD_WIDTH-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [PERIOD_WIDTH-1:0] hist0_q, hist0_d, hist1_q, hist1_d;
  logic [PERIOD_WIDTH-1:0] filt_q, filt_d;
  logic                    illegal_d;

  logic                    a_edge, b_edge, step_en, step_up, long_interval;
  logic [SumW-1:0]         interval_sum;
  logic [ProdW-1:0]        avg_prod, avg_shifted;
  logic [63:0]             count_ext;
  logic [31:0]             filt_ext;

  logic [POSITION_W-1:0]   pos_q;
  logic                    cw_q;
  logic [PERIOD_OUT_W-1:0] per_q;
  logic                    illegal_q;

  assign advance     = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready  = !in_v_q || !out_v_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    a_edge        = pin_a_q ^ last_a_q;
    b_edge        = pin_b_q ^ last_b_q;
    elapsed_inc   = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
    interval_sum  = SumW'(elapsed_inc) + SumW'(hist0_q) + SumW'(hist1_q);
    avg_prod      = ProdW'(interval_sum) * ProdW'(AVG_MUL);
    avg_shifted   = avg_prod >> AVG_SHIFT;
    long_interval = 32'(elapsed_inc) > 32'(min_period_q);

    elapsed_d = elapsed_inc;
    hist0_d   = hist0_q;
    hist1_d   = hist1_q;
    filt_d    = filt_q;
    illegal_d = 1'b0;
    step_en   = 1'b0;
    step_up   = 1'b0;

    if (a_edge && b_edge) begin
      illegal_d = 1'b1;
    end else if (a_edge) begin
      step_en   = 1'b1;
      step_up   = pin_a_q != pin_b_q;
      elapsed_d = '0;
      if (long_interval) begin
        filt_d  = avg_shifted[PERIOD_WIDTH-1:0];
        hist1_d = hist0_q;
        hist0_d = elapsed_inc;
      end
    end else if (b_edge) begin
      step_en = 1'b1;
      step_up = pin_a_q == pin_b_q;
    end

    count_d = count_q;
    dir_d   = dir_q;
    if (step_en) begin
      count_d = step_up ? count_q + 1'b1 : count_q - 1'b1;
      dir_d   = !step_up;
    end

    count_ext = 64'(count_d);
    filt_ext  = 32'(filt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      min_period_q <= MIN_PERIOD_RESET;
      last_a_q     <= 1'b0;
      last_b_q     <= 1'b0;
      count_q      <= '0;
      dir_q        <= 1'b0;
      elapsed_q    <= '0;
      hist0_q      <= '0;
      hist1_q      <= '0;
      filt_q       <= '0;
    end else begin
      if (cfg_i.valid) begin
        min_period_q <= cfg_i.min_period;
      end
      if (in_i.valid && in_i.ready) begin
        in_v_q <= 1'b1;
      end else if (advance) begin
        in_v_q <= 1'b0;
      end
      if (advance) begin
        out_v_q   <= 1'b1;
        last_a_q  <= pin_a_q;
        last_b_q  <= pin_b_q;
        count_q   <= count_d;
        dir_q     <= dir_d;
        elapsed_q <= elapsed_d;
        hist0_q   <= hist0_d;
        hist1_q   <= hist1_d;
        filt_q    <= filt_d;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      pin_a_q <= in_i.pin_a;
      pin_b_q <= in_i.pin_b;
    end
    if (advance) begin
      pos_q     <= count_ext[POSITION_W-1:0];
      cw_q      <= dir_d;
      per_q     <= filt_ext[PERIOD_OUT_W-1:0];
      illegal_q <= illegal_d;
    end
  end

  assign out_o.valid           = out_v_q;
  assign out_o.position        = $signed(pos_q);
  assign out_o.clockwise       = cw_q;
  assign out_o.period_filtered = per_q;
  assign out_o.illegal         = illegal_q;

endmodule

// File: rtl/qdpf_checker.sv
// Port-level checks for the quadrature decoder, attached by bind.
// Depends on qdpf_pkg; bound to quadrature_decoder_with_period_filter_unit.
module qdpf_checker import qdpf_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic signed [POSITION_W-1:0] position_i,
  input logic                         clockwise_i,
  input logic                         illegal_i
);

  logic                  in_acc, out_acc;
  logic [1:0]            pending_q;
  logic [POSITION_W-1:0] last_pos_q;
  logic                  last_cw_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= '0;
      last_pos_q <= '0;
      last_cw_q  <= 1'b0;
    end else begin
      pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        last_pos_q <= position_i;
        last_cw_q  <= clockwise_i;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(position_i))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 2'd0)
    else $error("result without an accepted item");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 2'd0 |-> in_ready_i)
    else $error("empty block refused an item");

  a_unit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> position_i == last_pos_q || position_i == last_pos_q + 1'b1 ||
                position_i == last_pos_q - 1'b1)
    else $error("position moved by more than one");

  a_illegal_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && illegal_i |-> position_i == last_pos_q && clockwise_i == last_cw_q)
    else $error("illegal sample moved the count");

endmodule

bind quadrature_decoder_with_period_filter_unit qdpf_checker u_qdpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .position_i  (out_o.position),
  .clockwise_i (out_o.clockwise),
  .illegal_i   (out_o.illegal)
);

// File: tb/quadrature_decoder_with_period_filter_unit_tb.sv
// Self-checking bench for quadrature_decoder_with_period_filter_unit.
// Drives encoder samples with random gaps and stalls, predicts each result
// in a behavioral decoder, and checks every field. Needs qdpf_pkg and qdpf_ifs.
module quadrature_decoder_with_period_filter_unit_tb;
  import qdpf_pkg::*;

  typedef struct packed {
    logic signed [POSITION_W-1:0] position;
    logic                         clockwise;
    logic [PERIOD_OUT_W-1:0]      period;
    logic                         illegal;
  } result_t;

  typedef struct {
    bit      a;
    bit      b;
    bit      typed;
    result_t want;
  } row_t;

  localparam int N_DIR = 20;
  localparam int SIM_LIMIT = 1_000_000;

  logic clk_i;
  logic rst_ni;

  qdpf_in_if  in_if ();
  qdpf_out_if out_if ();
  qdpf_cfg_if cfg_if ();

  quadrature_decoder_with_period_filter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // decoder state mirror
  bit                      pr_last_a;
  bit                      pr_last_b;
  logic [31:0]             pr_count;
  bit                      pr_dir;
  logic [23:0]             pr_elapsed;
  logic [23:0]             pr_hist [2];
  logic [23:0]             pr_filt;
  logic [MIN_PERIOD_W-1:0] pr_min;

  result_t expected_results [$];
  int      errors;
  int      samples_sent;
  int      results_checked;
  int      illegal_seen;
  int      filter_updates;
  int      cfg_writes;
  bit      idle_on;
  int      squeeze_cycles;

  row_t dir_rows [N_DIR] = '{
    '{1'b0, 1'b0, 1'b1, '{32'sd0, 1'b0, 24'd0, 1'b0}},
    '{1'b1, 1'b0, 1'b1, '{32'sd1, 1'b0, 24'd0, 1'b0}},
    '{1'b1, 1'b1, 1'b1, '{32'sd2, 1'b0, 24'd0, 1'b0}},
    '{1'b0, 1'b1, 1'b1, '{32'sd3, 1'b0, 24'd0, 1'b0}},
    '{1'b0, 1'b0, 1'b1, '{32'sd4, 1'b0, 24'd0, 1'b0}},
    '{1'b0, 1'b1, 1'b1, '{32'sd3, 1'b1, 24'd0, 1'b0}},
    '{1'b1, 1'b0, 1'b1, '{32'sd3, 1'b1, 24'd0, 1'b1}},
    '{1'b1, 1'b0, 1'b1, '{32'sd3, 1'b1, 24'd0, 1'b0}},
    '{1'b0, 1'b0, 1'b1, '{32'sd2, 1'b1, 24'd0, 1'b0}},
    '{1'b0, 1'b1, 1'b1, '{32'sd1, 1'b1, 24'd0, 1'b0}},
    '{1'b1, 1'b1, 1'b1, '{32'sd0, 1'b1, 24'd0, 1'b0}},
    '{1'b1, 1'b0, 1'b1, '{-32'sd1, 1'b1, 24'd0, 1'b0}},
    '{1'b0, 1'b1, 1'b1, '{-32'sd1, 1'b1, 24'd0, 1'b1}},
    '{1'b0, 1'b0, 1'b1, '{32'sd0, 1'b0, 24'd0, 1'b0}},
    '{1'b1, 1'b0, 1'b0, '{32'sd0, 1'b0, 24'd0, 1'b0}},
    '{1'b0, 1'b0, 1'b0, '{32'sd0, 1'b0, 24'd0, 1'b0}},
    '{1'b1, 1'b0, 1'b0, '{32'sd0, 1'b0, 24'd0, 1'b0}},
    '{1'b0, 1'b0, 1'b0, '{32'sd0, 1'b0, 24'd0, 1'b0}},
    '{1'b0, 1'b1, 1'b0, '{32'sd0, 1'b0, 24'd0, 1'b0}},
    '{1'b1, 1'b1, 1'b0, '{32'sd0, 1'b0, 24'd0, 1'b0}}
  };

  function automatic void step_count(bit up);
    if (up) begin
      pr_count = pr_count + 32'd1;
      pr_dir   = 1'b0;
    end else begin
      pr_count = pr_count - 32'd1;
      pr_dir   = 1'b1;
    end
  endfunction

  function automatic result_t decode_sample(bit a, bit b);
    result_t     r;
    bit          a_edge;
    bit          b_edge;
    logic [23:0] interval;
    logic [63:0] sum;
    a_edge = (a != pr_last_a);
    b_edge = (b != pr_last_b);
    r.illegal = 1'b0;
    if (pr_elapsed != 24'hFFFFFF) pr_elapsed = pr_elapsed + 24'd1;
    if (a_edge && b_edge) begin
      r.illegal = 1'b1;
    end else if (a_edge) begin
      interval = pr_elapsed;
      step_count(a != b);
      pr_elapsed = '0;
      if (interval > {8'd0, pr_min}) begin
        sum = 64'(interval) + 64'(pr_hist[0]) + 64'(pr_hist[1]);
        pr_filt = 24'((sum * 64'(AVG_MUL)) >> AVG_SHIFT);
        pr_hist[1] = pr_hist[0];
        pr_hist[0] = interval;
        filter_updates++;
      end
    end else if (b_edge) begin
      step_count(a == b);
    end
    pr_last_a = a;
    pr_last_b = b;
    r.position  = pr_count;
    r.clockwise = pr_dir;
    r.period    = pr_filt;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_sample(bit a, bit b, bit typed, result_t want);
    int      gap;
    result_t r;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.pin_a <= a;
    in_if.pin_b <= b;
    do @(posedge clk_i); while (!in_if.ready);
    r = decode_sample(a, b);
    if (r.illegal) illegal_seen++;
    expected_results.push_back(typed ? want : r);
    samples_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_min_period(logic [MIN_PERIOD_W-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.min_period <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    pr_min = v;
    cfg_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // random walk: single-channel flips, hold runs, double flips, noise
  task automatic walk(int n, int hold_lo, int hold_hi);
    int sent;
    int r;
    int h;
    bit a;
    bit b;
    sent = 0;
    while (sent < n) begin
      a = pr_last_a;
      b = pr_last_b;
      r = $urandom_range(0, 99);
      if (r < 40) a = ~a;
      else if (r < 70) b = ~b;
      else if (r < 90) begin
        h = $urandom_range(hold_lo, hold_hi);
        repeat (h) begin
          send_sample(a, b, 1'b0, '0);
          sent++;
        end
        continue;
      end else if (r < 95) begin
        a = ~a;
        b = ~b;
      end else begin
        a = 1'($urandom);
        b = 1'($urandom);
      end
      send_sample(a, b, 1'b0, '0);
      sent++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(SIM_LIMIT);
    $display("quadrature_decoder_with_period_filter_unit_tb NOT OK");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    int r;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_cycles > 0) begin
        out_if.ready <= 1'b0;
        squeeze_cycles--;
      end else if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        r = $urandom_range(0, 99);
        if (idle_on && r < 25) begin
          out_if.ready <= 1'b0;
          stall = (r < 22) ? $urandom_range(0, 2) : $urandom_range(10, 30);
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    result_t e;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: position %0d", $time, out_if.position);
        errors++;
      end else begin
        e = expected_results.pop_front();
        results_checked++;
        if (out_if.position !== e.position) begin
          $display("%0t position: expected %0d got %0d", $time, e.position, out_if.position);
          errors++;
        end
        if (out_if.clockwise !== e.clockwise) begin
          $display("%0t clockwise: expected %0b got %0b", $time, e.clockwise, out_if.clockwise);
          errors++;
        end
        if (out_if.period_filtered !== e.period) begin
          $display("%0t period_filtered: expected %0d got %0d", $time, e.period,
                   out_if.period_filtered);
          errors++;
        end
        if (out_if.illegal !== e.illegal) begin
          $display("%0t illegal: expected %0b got %0b", $time, e.illegal, out_if.illegal);
          errors++;
        end
      end
    end
  end

  initial begin
    int w;
    errors          = 0;
    samples_sent    = 0;
    results_checked = 0;
    illegal_seen    = 0;
    filter_updates  = 0;
    cfg_writes      = 0;
    idle_on         = 1'b1;
    squeeze_cycles  = 0;
    pr_last_a  = 1'b0;
    pr_last_b  = 1'b0;
    pr_count   = '0;
    pr_dir     = 1'b0;
    pr_elapsed = '0;
    pr_hist[0] = '0;
    pr_hist[1] = '0;
    pr_filt    = '0;
    pr_min     = MIN_PERIOD_RESET;
    in_if.valid       = 1'b0;
    in_if.pin_a       = 1'b0;
    in_if.pin_b       = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.min_period = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIR; i++)
      send_sample(dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

    // every A edge feeds the filter; start with a long receiver hold-off
    write_min_period(16'd0);
    idle_on = 1'b0;
    squeeze_cycles = 40;
    walk(30, 0, 3);
    idle_on = 1'b1;
    walk(100, 0, 4);

    w = $urandom_range(2, 40);
    write_min_period(16'(w));
    walk(120, (w > 3) ? w - 3 : 0, w + 2);

    // reset value again, short intervals leave the filter alone
    write_min_period(MIN_PERIOD_RESET);
    walk(60, 0, 8);

    write_min_period(16'hFFFF);
    walk(40, 0, 8);

    write_min_period(16'd1);
    walk(30, 0, 3);

    drain();
    $display("%0d samples, %0d results checked, %0d illegal samples", samples_sent,
             results_checked, illegal_seen);
    $display("%0d filter updates across %0d min_period settings", filter_updates, cfg_writes);
    if (errors == 0) begin
      $display("quadrature_decoder_with_period_filter_unit_tb OK");
    end else begin
      $display("quadrature_decoder_with_period_filter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/qdpf_pkg.sv
rtl/qdpf_ifs.sv
rtl/quadrature_decoder_with_period_filter_unit.sv
rtl/qdpf_checker.sv
tb/quadrature_decoder_with_period_filter_unit_tb.sv
